// ===== hw/rtl/i2cbe_pkg.sv =====
// I2C master bit engine: shared types, operation codes and register indexes.
// Used by i2cbe_engine and i2c_master_bit_engine_top; no dependencies.
`default_nettype none

package i2cbe_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int PHASE_W       = 16;
   localparam int TIMEOUT_W     = 8;
   localparam int CSR_ADDR_W    = 1;
   localparam int CSR_DATA_W    = 16;

   localparam logic [PHASE_W-1:0]   PHASE_TICKS_RST = 16'd8;
   localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 8'd250;

   localparam logic [CSR_ADDR_W-1:0] CSR_PHASE_TICKS = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACK_TIMEOUT = 1'b1;

   typedef enum logic [2:0] {
      OP_START = 3'd0,
      OP_STOP  = 3'd1,
      OP_WRITE = 3'd2,
      OP_RACK  = 3'd3,
      OP_READ  = 3'd4,
      OP_SACK  = 3'd5,
      OP_IDLE  = 3'd7
   } op_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] mode;
      logic [7:0] tx_byte;
      logic       nack;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_missing;
   } rsp_type;

   typedef struct packed {
      logic [PHASE_W-1:0]   phase_ticks;
      logic [TIMEOUT_W-1:0] ack_timeout;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/i2cbe_engine.sv =====
// I2C master bit engine state and per-tick update logic.
// Depends on i2cbe_pkg for the operation codes and the item structs.
`default_nettype none

module i2cbe_engine #(
   parameter int BITS_PER_BYTE = i2cbe_pkg::BITS_PER_BYTE
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               step,
   input  i2cbe_pkg::req_type req,
   input  i2cbe_pkg::cfg_type cfg,
   output i2cbe_pkg::rsp_type rsp
);

   i2cbe_pkg::op_type op_ff, op_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  poll_ff, poll_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        dir_ff, dir_in;
   logic        ack_ff, ack_in;
   logic        nack_ff, nack_in;
   logic [7:0]  rx_ff, rx_in;
   logic        done;
   logic        do_poll;
   logic [15:0] pt;
   logic [3:0]  bit_inc;

   assign pt      = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
   assign bit_inc = bit_ff + 4'd1;

   always_comb begin
      op_in    = op_ff;
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      poll_in  = poll_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      dir_in   = dir_ff;
      ack_in   = ack_ff;
      nack_in  = nack_ff;
      rx_in    = rx_ff;
      done     = 1'b0;
      do_poll  = 1'b0;

      if (op_ff == i2cbe_pkg::OP_IDLE) begin
         if (req.cmd_valid && (req.mode <= 3'(i2cbe_pkg::OP_SACK))) begin
            op_in    = i2cbe_pkg::op_type'(req.mode);
            bit_in   = 4'd0;
            phase_in = 2'd0;
            tick_in  = 16'd1;
            case (i2cbe_pkg::op_type'(req.mode))
               i2cbe_pkg::OP_START: begin
                  dir_in = 1'b1; sda_in = 1'b1; scl_in = 1'b1;
               end
               i2cbe_pkg::OP_STOP: begin
                  dir_in = 1'b1; sda_in = 1'b0; scl_in = 1'b1;
               end
               i2cbe_pkg::OP_WRITE: begin
                  dir_in   = 1'b1;
                  scl_in   = 1'b0;
                  sda_in   = req.tx_byte[7];
                  shift_in = {req.tx_byte[6:0], 1'b0};
               end
               i2cbe_pkg::OP_RACK: begin
                  dir_in = 1'b0; sda_in = 1'b1; poll_in = 8'd0;
               end
               i2cbe_pkg::OP_READ: begin
                  dir_in = 1'b0; sda_in = 1'b1; shift_in = 8'd0;
               end
               default: begin
                  dir_in = 1'b1; scl_in = 1'b0; nack_in = req.nack;
               end
            endcase
         end
      end else if (op_ff == i2cbe_pkg::OP_RACK && phase_ff == 2'd2) begin
         do_poll = 1'b1;
      end else if (tick_ff < pt) begin
         tick_in = tick_ff + 16'd1;
      end else begin
         // phase boundary: apply the next actions of the running command
         tick_in = 16'd1;
         case (op_ff)
            i2cbe_pkg::OP_START: begin
               if (phase_ff == 2'd0) begin
                  sda_in = 1'b0; phase_in = 2'd1;
               end else begin
                  scl_in = 1'b0; done = 1'b1;
               end
            end
            i2cbe_pkg::OP_STOP: begin
               if (phase_ff == 2'd0) begin
                  sda_in = 1'b1; phase_in = 2'd1;
               end else begin
                  done = 1'b1;
               end
            end
            i2cbe_pkg::OP_SACK: begin
               if (phase_ff == 2'd0) begin
                  sda_in = nack_ff; scl_in = 1'b1; phase_in = 2'd1;
               end else if (phase_ff == 2'd1) begin
                  scl_in = 1'b0; phase_in = 2'd2;
               end else begin
                  done = 1'b1;
               end
            end
            i2cbe_pkg::OP_RACK: begin
               if (phase_ff == 2'd0) begin
                  scl_in = 1'b1; phase_in = 2'd1;
               end else begin
                  phase_in = 2'd2; tick_in = 16'd0; do_poll = 1'b1;
               end
            end
            i2cbe_pkg::OP_WRITE: begin
               if (phase_ff == 2'd0) begin
                  scl_in = 1'b1; phase_in = 2'd1;
               end else if (phase_ff == 2'd1) begin
                  scl_in = 1'b0; phase_in = 2'd2;
               end else begin
                  bit_in = bit_inc;
                  if (bit_inc >= 4'(BITS_PER_BYTE)) begin
                     done = 1'b1;
                  end else begin
                     sda_in   = shift_ff[7];
                     shift_in = {shift_ff[6:0], 1'b0};
                     phase_in = 2'd0;
                  end
               end
            end
            i2cbe_pkg::OP_READ: begin
               if (phase_ff == 2'd0) begin
                  scl_in = 1'b1; phase_in = 2'd1;
               end else if (phase_ff == 2'd1) begin
                  shift_in = {shift_ff[6:0], req.sda_in};
                  scl_in   = 1'b0;
                  phase_in = 2'd2;
               end else begin
                  bit_in = bit_inc;
                  if (bit_inc >= 4'(BITS_PER_BYTE)) begin
                     rx_in = shift_ff; done = 1'b1;
                  end else begin
                     phase_in = 2'd0;
                  end
               end
            end
            default: done = 1'b1;
         endcase
      end

      // sample the ACK slot once per tick
      if (do_poll) begin
         if (!req.sda_in) begin
            scl_in = 1'b0; ack_in = 1'b0; done = 1'b1;
         end else if (poll_ff >= cfg.ack_timeout) begin
            ack_in   = 1'b1;
            op_in    = i2cbe_pkg::OP_STOP;
            dir_in   = 1'b1;
            sda_in   = 1'b0;
            scl_in   = 1'b1;
            phase_in = 2'd0;
            tick_in  = 16'd1;
         end else begin
            poll_in = poll_ff + 8'd1;
         end
      end

      if (done) begin
         op_in    = i2cbe_pkg::OP_IDLE;
         phase_in = 2'd0;
         tick_in  = 16'd0;
      end
   end

   always_comb begin
      rsp.scl         = scl_in;
      rsp.sda_out     = sda_in;
      rsp.sda_drive   = dir_in;
      rsp.busy_res    = (op_in != i2cbe_pkg::OP_IDLE);
      rsp.done_res    = done;
      rsp.rx_byte     = rx_in;
      rsp.ack_missing = ack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff    <= i2cbe_pkg::OP_IDLE;
         phase_ff <= 2'd0;
         tick_ff  <= 16'd0;
         bit_ff   <= 4'd0;
         shift_ff <= 8'd0;
         poll_ff  <= 8'd0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         dir_ff   <= 1'b1;
         ack_ff   <= 1'b0;
         nack_ff  <= 1'b0;
         rx_ff    <= 8'd0;
      end else if (step) begin
         op_ff    <= op_in;
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         poll_ff  <= poll_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         dir_ff   <= dir_in;
         ack_ff   <= ack_in;
         nack_ff  <= nack_in;
         rx_ff    <= rx_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/i2c_master_bit_engine_top.sv =====
// I2C master bit engine top level: input register, engine, result register, CSRs.
// Depends on i2cbe_pkg and i2cbe_engine.
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  cmd_valid, mode, tx_byte, nack, sda_in
// rsp_      out        rsp_valid/rsp_stall  scl, sda_out, sda_drive, busy_res,
//                                           done_res, rx_byte, ack_missing
// csr_      in         csr_we               csr_addr, csr_wdata
//
// One item per cycle sustained while rsp_stall is low; each item's result is offered
// on rsp_ once it has passed the input register and then the engine update into
// the result register.
// The engine's per-tick state update is the single step between those registers.
// Reset is synchronous, active high; it restores the bus-released state and the
// register defaults (phase_ticks 8, ack_timeout 250).
// A stall on rsp_ holds the result register and backs up into req_stall only
// once both the input register and the result register are full.

module i2c_master_bit_engine_top #(
   parameter int BITS_PER_BYTE = i2cbe_pkg::BITS_PER_BYTE
) (
   input  wire        clock,
   input  wire        reset,
   // input items
   input  wire        req_valid,
   output logic       req_stall,
   input  wire        req_cmd_valid,
   input  wire [2:0]  req_mode,
   input  wire [7:0]  req_tx_byte,
   input  wire        req_nack,
   input  wire        req_sda_in,
   // result items
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic       rsp_scl,
   output logic       rsp_sda_out,
   output logic       rsp_sda_drive,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_ack_missing,
   // configuration
   input  wire                              csr_we,
   input  wire [i2cbe_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire [i2cbe_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic               in_valid_ff, in_valid_in;
   i2cbe_pkg::req_type in_ff;
   logic               out_valid_ff, out_valid_in;
   i2cbe_pkg::rsp_type out_ff;
   i2cbe_pkg::rsp_type eng_rsp;
   i2cbe_pkg::cfg_type cfg_ff;
   logic               advance;
   logic               step;

   // result register can take a new item when empty or being drained
   assign advance      = !out_valid_ff || !rsp_stall;
   assign step         = in_valid_ff && advance;
   assign req_stall    = in_valid_ff && !advance;
   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_ticks <= i2cbe_pkg::PHASE_TICKS_RST;
         cfg_ff.ack_timeout <= i2cbe_pkg::ACK_TIMEOUT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            i2cbe_pkg::CSR_PHASE_TICKS: cfg_ff.phase_ticks <= csr_wdata;
            i2cbe_pkg::CSR_ACK_TIMEOUT:
               cfg_ff.ack_timeout <= csr_wdata[i2cbe_pkg::TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   // input register: hold while stalled, load on every accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff.cmd_valid <= req_cmd_valid;
         in_ff.mode      <= req_mode;
         in_ff.tx_byte   <= req_tx_byte;
         in_ff.nack      <= req_nack;
         in_ff.sda_in    <= req_sda_in;
      end
   end

   i2cbe_engine #(
      .BITS_PER_BYTE (BITS_PER_BYTE)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (in_ff),
      .cfg   (cfg_ff),
      .rsp   (eng_rsp)
   );

   // result register: advance when empty or when the downstream side takes the item
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= eng_rsp;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_scl         = out_ff.scl;
   assign rsp_sda_out     = out_ff.sda_out;
   assign rsp_sda_drive   = out_ff.sda_drive;
   assign rsp_busy_res    = out_ff.busy_res;
   assign rsp_done_res    = out_ff.done_res;
   assign rsp_rx_byte     = out_ff.rx_byte;
   assign rsp_ack_missing = out_ff.ack_missing;

   // a finished command never reports busy on its done tick
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while busy");

   // a released SDA line always has its output level high
   a_released_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sda_drive |-> rsp_sda_out)
      else $error("SDA released but driven level low");

   // back-pressure only when both pipeline registers hold items
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
